### src/pli_pkg.sv
package pli_pkg;

   // list storage geometry
   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // field widths of the ports
   localparam int DATA_W  = 32;
   localparam int POS_W   = 5;
   localparam int CAP_W   = 5;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 2;

   // one traverse gives at most sixteen results
   localparam int LIM_MAX = (DEPTH < 16) ? DEPTH : 16;

   // width that holds positions, counts and count + 1 without overflow
   localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT   = 2'd0,
      ACT_DELETE   = 2'd1,
      ACT_TRAVERSE = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INSERT,
      SEQ_PUT,
      SEQ_DELETE,
      SEQ_TRAVERSE,
      SEQ_ERROR
   } seq_state_type;

   // one write and one read access to the entry memory per cycle
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  waddr;
      logic [DATA_W-1:0] wdata;
      logic [IDX_W-1:0]  raddr;
   } mem_req_type;

   // one result item
   typedef struct packed {
      logic              strobe;
      status_type        status;
      logic [DATA_W-1:0] element;
      logic              last;
   } rsp_type;

endpackage

### src/positional_list_insert_delete_core.sv
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  ------------------------------
// request   req_action, req_value, req_position           taken when start && !busy
// result    rsp_status, rsp_element, rsp_last             valid for one cycle on rsp_strobe
// config    csr_wdata (capacity)                          written when csr_we
//
// Insert at slot s of n held entries: a read/write sweep of the entry memory,
// which has a single write port, moves the entries from the top down to slot s
// one place up, then a final write stores the new value; an append at the end
// shifts nothing. Delete reads the removed entry, moving later ones one place down.
// Traverse gives one result per cycle after the first read; an error gives one result.
// Reset is synchronous and empties the list; capacity returns to 16.
// The receiver cannot stall; a result stands on the ports for exactly one cycle.
module positional_list_insert_delete_core
   import pli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   output logic                     rsp_strobe,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_element,
   output logic                     rsp_last,
   input  logic                     csr_we,
   input  logic [CAP_W-1:0]         csr_wdata
);

   logic [CNT_W-1:0]  limit_ff, limit_in;
   rsp_type           rsp;
   mem_req_type       mem_req;
   logic [DATA_W-1:0] mem_rdata;

   // clamp the written capacity to the storage depth and the traverse bound
   always_comb begin
      if (CMP_W'(csr_wdata) > CMP_W'(LIM_MAX)) begin
         limit_in = CNT_W'(LIM_MAX);
      end else begin
         limit_in = CNT_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= CNT_W'(LIM_MAX);
      end else if (csr_we) begin
         limit_ff <= limit_in;
      end
   end

   pli_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .limit        (limit_ff),
      .busy         (busy),
      .rsp          (rsp),
      .mem_req      (mem_req),
      .mem_rdata    (mem_rdata)
   );

   pli_ram u_ram (
      .clock     (clock),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   assign rsp_strobe  = rsp.strobe;
   assign rsp_status  = rsp.status;
   assign rsp_element = rsp.element;
   assign rsp_last    = rsp.last;

   a_limit_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(limit_ff) <= CMP_W'(LIM_MAX))
      else $error("capacity limit beyond traverse bound");

   a_no_strobe_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_strobe)
      else $error("result right after reset");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_INSERT || req_action == ACT_DELETE ||
                          req_action == ACT_TRAVERSE)) |=> busy)
      else $error("accepted item did not start work");

endmodule

### src/pli_ram.sv
module pli_ram
   import pli_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       mem_req,
   output logic [DATA_W-1:0] mem_rdata
);

   logic [DATA_W-1:0] ram_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         ram_mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= ram_mem[mem_req.raddr];
   end

   assign mem_rdata = rd_data_ff;

endmodule

### src/pli_seq.sv
module pli_seq
   import pli_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ACT_W-1:0]         req_action,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic [POS_W-1:0]         req_position,
   input  logic [CNT_W-1:0]         limit,
   output logic                     busy,
   output rsp_type                  rsp,
   output mem_req_type              mem_req,
   input  logic [DATA_W-1:0]        mem_rdata
);

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rd_act_ff, rd_act_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  pa_ff, pa_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [DATA_W-1:0] got_ff, got_in;
   status_type        status_ff, status_in;

   logic [CMP_W-1:0]  n_ext;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  lim_ext;
   logic [CMP_W-1:0]  pos_m1;
   logic [IDX_W-1:0]  n_m1_idx;
   logic [IDX_W-1:0]  ins_slot;
   logic [IDX_W-1:0]  del_slot;
   logic              ins_bad;
   logic              del_bad;
   logic [IDX_W-1:0]  stop_addr;

   // decode the request against the current count
   always_comb begin
      n_ext    = CMP_W'(count_ff);
      pos_ext  = CMP_W'(req_position);
      lim_ext  = CMP_W'(limit);
      pos_m1   = pos_ext - CMP_W'(1);
      n_m1_idx = IDX_W'(count_ff - CNT_W'(1));
      ins_slot = (count_ff == '0) ? '0 : IDX_W'(pos_m1);
      del_slot = (count_ff == CNT_W'(1)) ? '0 : IDX_W'(pos_m1);
      ins_bad  = (count_ff != '0) &&
                 ((pos_ext == '0) || (pos_ext > n_ext + CMP_W'(1)));
      del_bad  = (count_ff != CNT_W'(1)) &&
                 ((pos_ext == '0) || (pos_ext > n_ext));
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SEQ_IDLE;
         count_ff  <= '0;
         rd_act_ff <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_act_ff <= rd_act_in;
         pend_ff   <= pend_in;
      end
   end

   // address and payload registers
   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      pa_ff     <= pa_in;
      slot_ff   <= slot_in;
      end_ff    <= end_in;
      value_ff  <= value_in;
      got_ff    <= got_in;
      status_ff <= status_in;
   end

   // next state, memory accesses and results
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rd_act_in = rd_act_ff;
      pend_in   = 1'b0;
      ptr_in    = ptr_ff;
      pa_in     = pa_ff;
      slot_in   = slot_ff;
      end_in    = end_ff;
      value_in  = value_ff;
      got_in    = got_ff;
      status_in = status_ff;

      mem_req       = '0;
      mem_req.raddr = ptr_ff;

      rsp         = '0;
      rsp.status  = STAT_OK;

      // issue the next read of a sweep; insert walks down, the others up
      stop_addr = (state_ff == SEQ_INSERT) ? slot_ff : end_ff;
      if (rd_act_ff && ((state_ff == SEQ_INSERT) || (state_ff == SEQ_DELETE) ||
                        (state_ff == SEQ_TRAVERSE))) begin
         pend_in = 1'b1;
         pa_in   = ptr_ff;
         if (ptr_ff == stop_addr) begin
            rd_act_in = 1'b0;
         end else if (state_ff == SEQ_INSERT) begin
            ptr_in = ptr_ff - IDX_W'(1);
         end else begin
            ptr_in = ptr_ff + IDX_W'(1);
         end
      end

      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               value_in = req_value;
               case (req_action)
                  ACT_INSERT: begin
                     if (n_ext >= lim_ext) begin
                        status_in = STAT_FULL;
                        state_in  = SEQ_ERROR;
                     end else if (ins_bad) begin
                        status_in = STAT_BADPOS;
                        state_in  = SEQ_ERROR;
                     end else begin
                        slot_in   = ins_slot;
                        ptr_in    = n_m1_idx;
                        count_in  = count_ff + CNT_W'(1);
                        rd_act_in = 1'b1;
                        // append needs no shift
                        if (CMP_W'(ins_slot) == n_ext) begin
                           state_in = SEQ_PUT;
                        end else begin
                           state_in = SEQ_INSERT;
                        end
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = SEQ_ERROR;
                     end else if (del_bad) begin
                        status_in = STAT_BADPOS;
                        state_in  = SEQ_ERROR;
                     end else begin
                        slot_in   = del_slot;
                        ptr_in    = del_slot;
                        end_in    = n_m1_idx;
                        count_in  = count_ff - CNT_W'(1);
                        rd_act_in = 1'b1;
                        state_in  = SEQ_DELETE;
                     end
                  end
                  ACT_TRAVERSE: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                        state_in  = SEQ_ERROR;
                     end else begin
                        ptr_in    = '0;
                        end_in    = n_m1_idx;
                        rd_act_in = 1'b1;
                        state_in  = SEQ_TRAVERSE;
                     end
                  end
                  default: begin
                     // unused action code: drop the item
                     state_in = SEQ_IDLE;
                  end
               endcase
            end
         end

         SEQ_INSERT: begin
            // move each read entry one place up
            if (pend_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pa_ff + IDX_W'(1);
               mem_req.wdata = mem_rdata;
               if (!rd_act_ff) begin
                  state_in = SEQ_PUT;
               end
            end
         end

         SEQ_PUT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_ff;
            mem_req.wdata = value_ff;
            rsp.strobe    = 1'b1;
            rsp.element   = value_ff;
            rsp.last      = 1'b1;
            rsp.status    = STAT_OK;
            rd_act_in     = 1'b0;
            state_in      = SEQ_IDLE;
         end

         SEQ_DELETE: begin
            // the first read is the removed entry, the rest move one place down
            if (pend_ff) begin
               if (pa_ff == slot_ff) begin
                  got_in = mem_rdata;
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = pa_ff - IDX_W'(1);
                  mem_req.wdata = mem_rdata;
               end
               if (!rd_act_ff) begin
                  rsp.strobe  = 1'b1;
                  rsp.status  = STAT_OK;
                  rsp.element = (pa_ff == slot_ff) ? mem_rdata : got_ff;
                  rsp.last    = 1'b1;
                  state_in    = SEQ_IDLE;
               end
            end
         end

         SEQ_TRAVERSE: begin
            if (pend_ff) begin
               rsp.strobe  = 1'b1;
               rsp.status  = STAT_OK;
               rsp.element = mem_rdata;
               rsp.last    = (pa_ff == end_ff);
               if (!rd_act_ff) begin
                  state_in = SEQ_IDLE;
               end
            end
         end

         SEQ_ERROR: begin
            rsp.strobe  = 1'b1;
            rsp.status  = status_ff;
            rsp.element = '0;
            rsp.last    = 1'b1;
            state_in    = SEQ_IDLE;
         end

         default: begin
            state_in  = SEQ_IDLE;
            rd_act_in = 1'b0;
         end
      endcase
   end

   assign busy = (state_ff != SEQ_IDLE);

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.strobe |-> (state_ff != SEQ_IDLE))
      else $error("result strobe while idle");

   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> (state_ff != SEQ_IDLE))
      else $error("memory write while idle");

   a_put_ends_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_PUT) |=> (state_ff == SEQ_IDLE))
      else $error("insert did not finish after the final write");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp.strobe && rsp.last) |=> (state_ff == SEQ_IDLE))
      else $error("busy after the final result of an item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(DEPTH))
      else $error("element count beyond storage depth");

endmodule

### tb/positional_list_insert_delete_core_tb.sv
`timescale 1ns / 1ps

module positional_list_insert_delete_core_tb;
   import pli_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_MAX    = 10;

   // action code that the block ignores
   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      status_type               status;
      logic signed [DATA_W-1:0] element;
      logic                     last;
   } list_reply_type;

   // one row of the directed table: a capacity write or one item
   typedef struct {
      bit                       cap_write;
      logic [CAP_W-1:0]         cap;
      logic [ACT_W-1:0]         action;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
      bit                       pinned;
      status_type               status;
      logic signed [DATA_W-1:0] element;
   } directed_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [ACT_W-1:0]         req_action = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic                     rsp_strobe;
   logic [STAT_W-1:0]        rsp_status;
   logic signed [DATA_W-1:0] rsp_element;
   logic                     rsp_last;
   logic                     csr_we = 1'b0;
   logic [CAP_W-1:0]         csr_wdata = '0;

   // shadow copy of the list and its capacity
   logic signed [DATA_W-1:0] shadow_cells [DEPTH];
   int                       shadow_count = 0;
   int                       shadow_capacity = 16;

   list_reply_type   step_replies [$];
   list_reply_type   pending_replies [$];
   directed_row_type directed_rows [$];

   int cycle_count = 0;
   int mismatches = 0;
   int items_sent = 0;
   int replies_seen = 0;
   int full_reports = 0;
   int long_traverses = 0;

   positional_list_insert_delete_core uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // cap the run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d replies outstanding", CYCLE_LIMIT,
                  pending_replies.size());
         $display("positional_list_insert_delete_core_tb: errors");
         $finish;
      end
   end

   function automatic int shadow_limit();
      return (shadow_capacity < LIM_MAX) ? shadow_capacity : LIM_MAX;
   endfunction

   function automatic void push_reply(status_type st, logic signed [DATA_W-1:0] el, logic lst);
      list_reply_type r;
      r.status  = st;
      r.element = el;
      r.last    = lst;
      step_replies.push_back(r);
   endfunction

   // apply one item to the shadow list and collect the replies it causes
   function automatic void list_apply(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                                      int pos);
      int n;
      int slot;
      n = shadow_count;
      step_replies.delete();
      case (act)
         ACT_INSERT: begin
            if (n >= shadow_limit()) begin
               push_reply(STAT_FULL, '0, 1'b1);
               full_reports++;
            end else if (n != 0 && (pos < 1 || pos > n + 1)) begin
               push_reply(STAT_BADPOS, '0, 1'b1);
            end else begin
               slot = (n == 0) ? 0 : pos - 1;
               for (int i = n; i > slot; i--) shadow_cells[i] = shadow_cells[i - 1];
               shadow_cells[slot] = val;
               shadow_count = n + 1;
               push_reply(STAT_OK, val, 1'b1);
            end
         end
         ACT_DELETE: begin
            if (n == 0) begin
               push_reply(STAT_EMPTY, '0, 1'b1);
            end else if (n != 1 && (pos < 1 || pos > n)) begin
               push_reply(STAT_BADPOS, '0, 1'b1);
            end else begin
               slot = (n == 1) ? 0 : pos - 1;
               push_reply(STAT_OK, shadow_cells[slot], 1'b1);
               for (int i = slot; i + 1 < n; i++) shadow_cells[i] = shadow_cells[i + 1];
               shadow_count = n - 1;
            end
         end
         ACT_TRAVERSE: begin
            if (n == 0) begin
               push_reply(STAT_EMPTY, '0, 1'b1);
            end else begin
               if (n > LIM_MAX) n = LIM_MAX;
               if (n >= 12) long_traverses++;
               for (int i = 0; i < n; i++) push_reply(STAT_OK, shadow_cells[i], i == n - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // offer one item, hold it until taken, then queue its expected replies
   task automatic issue(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
                        input logic [POS_W-1:0] pos, input bit pinned,
                        input status_type pin_status, input logic signed [DATA_W-1:0] pin_el);
      list_reply_type r;
      start        <= 1'b1;
      req_action   <= act;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock);
      while (busy) @(posedge clock);
      list_apply(act, val, pos);
      items_sent++;
      if (pinned) begin
         r.status  = pin_status;
         r.element = pin_el;
         r.last    = 1'b1;
         pending_replies.push_back(r);
      end else begin
         foreach (step_replies[i]) pending_replies.push_back(step_replies[i]);
      end
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // idle the sender before about 23 items in a hundred
   task automatic maybe_idle();
      if ($urandom_range(99) < 23) pause_sender($urandom_range(6, 1));
   endtask

   // wait until every reply is in and the block has settled
   task automatic drain();
      pause_sender(1);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] cap);
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_capacity = cap;
      @(posedge clock);
   endtask

   function automatic void table_op(logic [ACT_W-1:0] act, logic signed [DATA_W-1:0] val,
                                    logic [POS_W-1:0] pos, bit pinned, status_type st,
                                    logic signed [DATA_W-1:0] el);
      directed_row_type row;
      row.cap_write = 1'b0;
      row.cap       = '0;
      row.action    = act;
      row.value     = val;
      row.position  = pos;
      row.pinned    = pinned;
      row.status    = st;
      row.element   = el;
      directed_rows.push_back(row);
   endfunction

   function automatic void table_cap(logic [CAP_W-1:0] cap);
      directed_row_type row;
      row.cap_write = 1'b1;
      row.cap       = cap;
      row.action    = ACT_INSERT;
      row.value     = '0;
      row.position  = '0;
      row.pinned    = 1'b0;
      row.status    = STAT_OK;
      row.element   = '0;
      directed_rows.push_back(row);
   endfunction

   // random items: mostly well-formed positions, some out of range
   task automatic random_items(int count, int insert_pct, bit no_idle);
      int                       done;
      int                       roll;
      logic [ACT_W-1:0]         act;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         if (roll < insert_pct) act = ACT_INSERT;
         else if (roll >= 95) act = ACT_UNUSED;
         else if (roll % 4 == 0) act = ACT_TRAVERSE;
         else act = ACT_DELETE;

         case ($urandom_range(19))
            0:       val = 32'sh8000_0000;
            1:       val = 32'sh7fff_ffff;
            2:       val = '0;
            3:       val = -32'sd1;
            default: val = $urandom;
         endcase

         if ($urandom_range(99) < 20) pos = POS_W'($urandom_range(31, 0));
         else if (act == ACT_INSERT) pos = POS_W'($urandom_range(shadow_count + 1, 1));
         else if (act == ACT_DELETE)
            pos = POS_W'($urandom_range((shadow_count > 1) ? shadow_count : 1, 1));
         else pos = POS_W'($urandom_range(31, 0));

         if (!no_idle) maybe_idle();
         issue(act, val, pos, 1'b0, STAT_OK, '0);
         if (act != ACT_UNUSED) done++;
      end
   endtask

   // compare each reply with the oldest expectation
   always @(posedge clock) begin : reply_check
      list_reply_type want;
      if (!reset && rsp_strobe) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("unexpected reply: status %0d element %0d last %0b",
                        rsp_status, rsp_element, rsp_last);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status || rsp_element !== want.element ||
                rsp_last !== want.last) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display({"reply mismatch: expected status %0d element %0d last %0b,",
                            " got status %0d element %0d last %0b"},
                           want.status, want.element, want.last,
                           rsp_status, rsp_element, rsp_last);
            end
         end
      end
   end

   initial begin
      // empty list, extremes, bad positions, the ignored code, full list
      table_op(ACT_DELETE,   '0,            5'd1,  1'b1, STAT_EMPTY,  '0);
      table_op(ACT_TRAVERSE, '0,            5'd0,  1'b1, STAT_EMPTY,  '0);
      table_op(ACT_INSERT,   32'sh8000_0000, 5'd31, 1'b1, STAT_OK,     32'sh8000_0000);
      table_op(ACT_DELETE,   '0,            5'd0,  1'b1, STAT_OK,     32'sh8000_0000);
      table_op(ACT_INSERT,   32'sh7fff_ffff, 5'd0,  1'b1, STAT_OK,     32'sh7fff_ffff);
      table_op(ACT_INSERT,   -32'sd1,       5'd0,  1'b1, STAT_BADPOS, '0);
      table_op(ACT_INSERT,   '0,            5'd3,  1'b1, STAT_BADPOS, '0);
      table_op(ACT_INSERT,   -32'sd1,       5'd2,  1'b0, STAT_OK,     '0);
      table_op(ACT_INSERT,   32'sh5555_5555, 5'd1,  1'b0, STAT_OK,     '0);
      table_op(ACT_INSERT,   32'shaaaa_aaaa, 5'd2,  1'b0, STAT_OK,     '0);
      table_op(ACT_DELETE,   '0,            5'd0,  1'b1, STAT_BADPOS, '0);
      table_op(ACT_DELETE,   '0,            5'd5,  1'b1, STAT_BADPOS, '0);
      table_op(ACT_DELETE,   '0,            5'd31, 1'b1, STAT_BADPOS, '0);
      table_op(ACT_TRAVERSE, '0,            5'd0,  1'b0, STAT_OK,     '0);
      table_op(ACT_UNUSED,   32'sh1234_5678, 5'd1,  1'b0, STAT_OK,     '0);
      table_op(ACT_DELETE,   '0,            5'd4,  1'b0, STAT_OK,     '0);
      table_op(ACT_DELETE,   '0,            5'd2,  1'b0, STAT_OK,     '0);
      table_op(ACT_TRAVERSE, '0,            5'd0,  1'b0, STAT_OK,     '0);
      table_cap(5'd2);
      table_op(ACT_INSERT,   32'sd1,        5'd1,  1'b1, STAT_FULL,   '0);
      table_cap(5'd0);
      table_op(ACT_INSERT,   32'sd7,        5'd1,  1'b1, STAT_FULL,   '0);
      table_cap(5'd16);

      // hold reset, then release it
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      shadow_count = 0;
      shadow_capacity = 16;
      @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cap_write) begin
            drain();
            write_capacity(directed_rows[i].cap);
         end else begin
            maybe_idle();
            issue(directed_rows[i].action, directed_rows[i].value, directed_rows[i].position,
                  directed_rows[i].pinned, directed_rows[i].status, directed_rows[i].element);
         end
      end
      drain();

      // fill toward the top with no idling, then sweep capacity settings
      write_capacity(5'd16);
      random_items(25, 80, 1'b1);
      drain();
      write_capacity(5'd31);
      random_items(12, 50, 1'b0);
      drain();
      write_capacity(5'd1);
      random_items(10, 55, 1'b0);
      drain();
      write_capacity(5'd0);
      random_items(6, 50, 1'b0);
      drain();
      write_capacity(5'd5);
      random_items(12, 50, 1'b0);
      drain();
      write_capacity(CAP_W'($urandom_range(31, 0)));
      random_items(15, 45, 1'b0);
      drain();

      $display("ran %0d items through capacities 16, 31, 1, 0, 5 and one random value",
               items_sent);
      $display("%0d replies checked, %0d full reports, %0d traverses of 12 or more",
               replies_seen, full_reports, long_traverses);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("positional_list_insert_delete_core_tb: clean");
      end else begin
         $display("%0d mismatches, %0d replies missing", mismatches, pending_replies.size());
         $display("positional_list_insert_delete_core_tb: errors");
      end
      $finish;
   end

endmodule
